@@ hdl/sorted_priority_queue_unit_defines.svh @@
// Assertion macros used by the sorted priority queue engine.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property whose consequent is checked in the clock cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define SPQ_ASSERT(label, clk, rst, prop, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

@@ hdl/spq_pkg.sv @@
// Types and constants of the sorted priority queue.
package spq_pkg;

   localparam int CAPACITY_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 16;
   localparam int VALUE_BITS        = 32;
   localparam int PRIORITY_IN_BITS  = 16;
   localparam int OP_BITS           = 2;
   localparam int STATUS_BITS       = 2;
   localparam int COUNT_OUT_BITS    = 5;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT  = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_READ,
      S_INS_CMP,
      S_HEAD_READ,
      S_HEAD_TAKE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                      valid;
      logic [VALUE_BITS-1:0]     value;
      status_type                status;
      logic [COUNT_OUT_BITS-1:0] count;
   } result_type;

endpackage

@@ hdl/spq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/spq_engine.sv @@
// Sequencer of the sorted priority queue: ring pointers, shared compare, insertion shifts.
`include "sorted_priority_queue_unit_defines.svh"

module spq_engine #(
   parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  spq_pkg::op_type                                op,
   input  logic [spq_pkg::VALUE_BITS-1:0]                 value,
   input  logic [PRIORITY_BITS-1:0]                       pri,
   output logic                                           ready,
   input  logic                                           out_free,
   output spq_pkg::result_type                            result,
   output logic                                           wr_en,
   output logic [$clog2(CAPACITY)-1:0]                    ram_addr,
   output logic [spq_pkg::VALUE_BITS+PRIORITY_BITS-1:0]   wr_data,
   input  logic [spq_pkg::VALUE_BITS+PRIORITY_BITS-1:0]   rd_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VB = spq_pkg::VALUE_BITS;
   localparam logic [CW-1:0] CAP_C      = CW'(CAPACITY);
   localparam logic [CW:0]   CAP_WIDE   = (CW+1)'(CAPACITY);
   localparam logic [IW:0]   CAP_HEAD   = (IW+1)'(CAPACITY);

   spq_pkg::state_type  state_ff, state_in;
   spq_pkg::op_type     op_ff, op_in;
   spq_pkg::status_type res_status_ff, res_status_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [VB-1:0]       new_val_ff, new_val_in;
   logic [PRIORITY_BITS-1:0] new_pri_ff, new_pri_in;
   logic [VB-1:0]       res_value_ff, res_value_in;

   logic [CW-1:0]            lidx;
   logic [CW:0]              phys_sum;
   logic [CW:0]              phys_wrap;
   logic [IW:0]              head_inc;
   logic [IW-1:0]            head_next;
   logic [PRIORITY_BITS-1:0] rd_pri;
   logic [VB-1:0]            rd_val;

   assign rd_pri = rd_data[VB+PRIORITY_BITS-1:VB];
   assign rd_val = rd_data[VB-1:0];

   // Logical slot to ring address; the sum stays below twice the capacity.
   always_comb begin
      if (state_ff == spq_pkg::S_INS_READ && idx_ff != '0) begin
         lidx = idx_ff - CW'(1);
      end else begin
         lidx = idx_ff;
      end
      phys_sum  = (CW+1)'(head_ff) + (CW+1)'(lidx);
      phys_wrap = (phys_sum >= CAP_WIDE) ? phys_sum - CAP_WIDE : phys_sum;
      ram_addr  = phys_wrap[IW-1:0];
      head_inc  = (IW+1)'(head_ff) + (IW+1)'(1);
      head_next = (head_inc == CAP_HEAD) ? '0 : head_inc[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      new_val_ff    <= new_val_in;
      new_pri_ff    <= new_pri_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      new_val_in    = new_val_ff;
      new_pri_in    = new_pri_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_data       = {new_pri_ff, new_val_ff};
      unique case (state_ff)
         spq_pkg::S_IDLE: begin
            if (start) begin
               op_in         = op;
               new_val_in    = value;
               new_pri_in    = pri;
               idx_in        = '0;
               res_value_in  = '0;
               res_status_in = spq_pkg::ST_OK;
               unique case (op)
                  spq_pkg::OP_INSERT: begin
                     if (count_ff == CAP_C) begin
                        res_status_in = spq_pkg::ST_FULL;
                        state_in      = spq_pkg::S_DONE;
                     end else begin
                        idx_in   = count_ff;
                        state_in = spq_pkg::S_INS_READ;
                     end
                  end
                  spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = spq_pkg::ST_EMPTY;
                        state_in      = spq_pkg::S_DONE;
                     end else begin
                        state_in = spq_pkg::S_HEAD_READ;
                     end
                  end
                  spq_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = spq_pkg::S_DONE;
                  end
               endcase
            end
         end
         spq_pkg::S_INS_READ: begin
            // At slot zero the new entry lands; otherwise fetch the entry in front.
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = spq_pkg::S_DONE;
            end else begin
               state_in = spq_pkg::S_INS_CMP;
            end
         end
         spq_pkg::S_INS_CMP: begin
            wr_en = 1'b1;
            if (rd_pri <= new_pri_ff) begin
               count_in = count_ff + CW'(1);
               state_in = spq_pkg::S_DONE;
            end else begin
               // Shift the fetched entry back one slot and keep walking.
               wr_data  = rd_data;
               idx_in   = idx_ff - CW'(1);
               state_in = spq_pkg::S_INS_READ;
            end
         end
         spq_pkg::S_HEAD_READ: begin
            state_in = spq_pkg::S_HEAD_TAKE;
         end
         spq_pkg::S_HEAD_TAKE: begin
            res_value_in = rd_val;
            if (op_ff == spq_pkg::OP_DEQUEUE) begin
               head_in  = head_next;
               count_in = count_ff - CW'(1);
            end
            state_in = spq_pkg::S_DONE;
         end
         spq_pkg::S_DONE: begin
            if (out_free) begin
               state_in = spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   assign ready         = (state_ff == spq_pkg::S_IDLE);
   assign result.valid  = (state_ff == spq_pkg::S_DONE);
   assign result.value  = res_value_ff;
   assign result.status = res_status_ff;
   assign result.count  = spq_pkg::COUNT_OUT_BITS'(count_ff);

   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CAP_C, "entry count above capacity")
   `SPQ_ASSERT(a_write_in_insert, clock, reset, wr_en |-> (state_ff == spq_pkg::S_INS_READ || state_ff == spq_pkg::S_INS_CMP), "RAM write outside insert")
   `SPQ_ASSERT(a_head_nonempty, clock, reset, (state_ff == spq_pkg::S_HEAD_TAKE) |-> (count_ff != '0), "head read on empty queue")
   `SPQ_ASSERT_NEXT(a_full_refused, clock, reset, start && op == spq_pkg::OP_INSERT && count_ff == CAP_C, state_ff == spq_pkg::S_DONE && res_status_ff == spq_pkg::ST_FULL && count_ff == CAP_C, "full insert not refused")

endmodule

@@ hdl/sorted_priority_queue_unit.sv @@
// Sorted priority queue: entries sit in a RAM ring in ascending priority order, head
// at the ring pointer. One request is taken at a time and answered with one
// transaction. An insert walks back from the tail through one read port and one
// comparator, moving each entry with a larger priority number one slot back, each
// move being a read and then a compare and write. Dequeue and peek wait for the
// registered RAM read; clear and a refused request go straight to the result. A
// new request is taken while the previous result still waits to be picked up. No
// clearing pass: the queue is ready right after reset.
module sorted_priority_queue_unit #(
   parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [spq_pkg::OP_BITS-1:0]          req_op,
   input  logic signed [spq_pkg::VALUE_BITS-1:0] req_value,
   input  logic [spq_pkg::PRIORITY_IN_BITS-1:0] req_priority_req,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [spq_pkg::VALUE_BITS-1:0] rsp_head_value,
   output logic [spq_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [spq_pkg::COUNT_OUT_BITS-1:0]   rsp_count
);

   localparam int IW = $clog2(CAPACITY);
   localparam int DW = spq_pkg::VALUE_BITS + PRIORITY_BITS;

   logic                start;
   logic                ready;
   logic                out_free;
   spq_pkg::result_type result;
   logic                wr_en;
   logic [IW-1:0]       ram_addr;
   logic [DW-1:0]       wr_data;
   logic [DW-1:0]       rd_data;
   logic [PRIORITY_BITS-1:0] pri;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::VALUE_BITS-1:0]    rsp_value_ff;
   logic [spq_pkg::STATUS_BITS-1:0]   rsp_status_ff;
   logic [spq_pkg::COUNT_OUT_BITS-1:0] rsp_count_ff;

   assign req_stall = !ready;
   assign start     = req_valid && ready;
   assign pri       = PRIORITY_BITS'(req_priority_req);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   spq_engine #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (spq_pkg::op_type'(req_op)),
      .value    (req_value),
      .pri      (pri),
      .ready    (ready),
      .out_free (out_free),
      .result   (result),
      .wr_en    (wr_en),
      .ram_addr (ram_addr),
      .wr_data  (wr_data),
      .rd_data  (rd_data)
   );

   spq_ram #(
      .WIDTH (DW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ram_addr),
      .wr_data (wr_data),
      .rd_addr (ram_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      // Load the output stage only when it is empty or being drained.
      if (result.valid && out_free) begin
         rsp_value_ff  <= result.value;
         rsp_status_ff <= result.status;
         rsp_count_ff  <= result.count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the sorted priority queue unit.
module testbench;
   import spq_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEF;
   localparam int PRIO_BITS   = PRIORITY_BITS_DEF;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_EVERY = 400;
   localparam int TAIL_CYCLES = 40;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      status_type                   status;
      logic [COUNT_OUT_BITS-1:0]    count;
   } reply_t;

   typedef struct {
      op_type                       op;
      logic signed [VALUE_BITS-1:0] value;
      logic [PRIORITY_IN_BITS-1:0]  prio;
      bit                           typed;
      reply_t                       want;
   } step_t;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_kind;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_kind;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [OP_BITS-1:0]                   req_op = OP_INSERT;
   logic signed [VALUE_BITS-1:0]         req_value = '0;
   logic [PRIORITY_IN_BITS-1:0]          req_priority_req = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [VALUE_BITS-1:0]         rsp_head_value;
   logic [STATUS_BITS-1:0]               rsp_status;
   logic [COUNT_OUT_BITS-1:0]            rsp_count;

   // Typed expectation travelling with the transaction on the request port
   bit     row_typed = 1'b0;
   reply_t row_want;

   // Mirror of the queue contents, kept sorted like the block
   logic signed [VALUE_BITS-1:0] mirror_value [CAPACITY];
   logic [PRIO_BITS-1:0]         mirror_prio  [CAPACITY];
   int                           mirror_count = 0;

   reply_t    replies_due [$];
   int        error_count = 0;
   int        cycle_count = 0;
   int        burst_left = 0;
   int        mix_left = 0;
   mix_kind   mix = MIX_EVEN;
   int        stall_left = 0;
   stall_kind stall_mode = STALL_NONE;

   step_t steps [26] = '{
      '{OP_PEEK,    0, 16'h0000, 1'b1, '{0, ST_EMPTY, 0}},
      '{OP_DEQUEUE, 0, 16'h0000, 1'b1, '{0, ST_EMPTY, 0}},
      '{OP_CLEAR,   0, 16'h0000, 1'b1, '{0, ST_OK, 0}},
      '{OP_INSERT,  32'sh7fffffff, 16'hffff, 1'b1, '{0, ST_OK, 1}},
      '{OP_INSERT,  32'sh80000000, 16'h0000, 1'b1, '{0, ST_OK, 2}},
      '{OP_PEEK,    0, 16'h0000, 1'b1, '{32'sh80000000, ST_OK, 2}},
      '{OP_INSERT,  5, 16'h0000, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  -1, 16'hffff, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  0, 16'h8000, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  32'sh55555555, 16'h5555, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  32'shaaaaaaaa, 16'haaaa, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  100, 16'h8000, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  101, 16'h0003, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  102, 16'h0003, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  103, 16'hfffe, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  104, 16'h0001, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  105, 16'h8000, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  -7, 16'h00ff, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  106, 16'h0002, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  107, 16'hffff, 1'b0, '{0, ST_OK, 0}},
      '{OP_INSERT,  32'sh7fffffff, 16'h0000, 1'b1, '{0, ST_FULL, 16}},
      '{OP_DEQUEUE, 0, 16'h0000, 1'b1, '{32'sh80000000, ST_OK, 15}},
      '{OP_DEQUEUE, 0, 16'h0000, 1'b1, '{5, ST_OK, 14}},
      '{OP_PEEK,    0, 16'h0000, 1'b0, '{0, ST_OK, 0}},
      '{OP_CLEAR,   0, 16'hffff, 1'b1, '{0, ST_OK, 0}},
      '{OP_DEQUEUE, 0, 16'h0000, 1'b1, '{0, ST_EMPTY, 0}}
   };

   sorted_priority_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_head_value   (rsp_head_value),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one request to the mirror and return the answer it should produce
   function automatic reply_t apply_request(op_type op, logic signed [VALUE_BITS-1:0] val,
                                            logic [PRIORITY_IN_BITS-1:0] pri_in);
      reply_t               r;
      logic [PRIO_BITS-1:0] pri;
      int                   pos;
      int                   i;
      pri = pri_in[PRIO_BITS-1:0];
      r.value = '0;
      r.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (mirror_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // Equal priorities go behind the ones already stored
               pos = 0;
               while (pos < mirror_count && mirror_prio[pos] <= pri) pos++;
               for (i = mirror_count; i > pos; i--) begin
                  mirror_value[i] = mirror_value[i-1];
                  mirror_prio[i]  = mirror_prio[i-1];
               end
               mirror_value[pos] = val;
               mirror_prio[pos]  = pri;
               mirror_count++;
            end
         end
         OP_DEQUEUE: begin
            if (mirror_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value = mirror_value[0];
               for (i = 1; i < mirror_count; i++) begin
                  mirror_value[i-1] = mirror_value[i];
                  mirror_prio[i-1]  = mirror_prio[i];
               end
               mirror_count--;
            end
         end
         OP_PEEK: begin
            if (mirror_count == 0) r.status = ST_EMPTY;
            else r.value = mirror_value[0];
         end
         default: begin
            mirror_count = 0;
         end
      endcase
      r.count = mirror_count[COUNT_OUT_BITS-1:0];
      return r;
   endfunction

   function automatic op_type pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return OP_CLEAR;
      case (mix)
         MIX_FILL:  return roll < 75 ? OP_INSERT : (roll < 88 ? OP_DEQUEUE : OP_PEEK);
         MIX_DRAIN: return roll < 25 ? OP_INSERT : (roll < 80 ? OP_DEQUEUE : OP_PEEK);
         default:   return roll < 45 ? OP_INSERT : (roll < 85 ? OP_DEQUEUE : OP_PEEK);
      endcase
   endfunction

   function automatic logic [PRIORITY_IN_BITS-1:0] pick_prio();
      int roll;
      roll = $urandom_range(0, 9);
      // Mostly a narrow range so that ties are common
      if (roll < 5) return PRIORITY_IN_BITS'($urandom_range(0, 7));
      if (roll < 8) return PRIORITY_IN_BITS'($urandom);
      if (roll == 8) return '0;
      return '1;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'sh80000000;
         1:       return 32'sh7fffffff;
         2:       return -1;
         3:       return 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(op_type op, logic signed [VALUE_BITS-1:0] val,
                            logic [PRIORITY_IN_BITS-1:0] pri, bit typed, reply_t want);
      req_valid <= 1'b1;
      req_op <= op;
      req_value <= val;
      req_priority_req <= pri;
      row_typed <= typed;
      row_want <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the next transaction back at the end of a burst
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3))
            @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 250)
                                                  : $urandom_range(1, 10);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (replies_due.size() != 0);
   endtask

   initial begin
      reply_t none;
      none = '{0, ST_OK, 0};
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      foreach (steps[r]) begin
         if (r != 0) pace();
         send_item(steps[r].op, steps[r].value, steps[r].prio, steps[r].typed, steps[r].want);
      end
      drain();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n != 0 && n % DRAIN_EVERY == 0) drain();
         else if (n != 0) pace();
         if (mix_left == 0) begin
            mix = mix_kind'($urandom_range(0, 2));
            mix_left = $urandom_range(15, 60);
         end
         mix_left--;
         send_item(pick_op(), pick_value(), pick_prio(), 1'b0, none);
      end
      req_valid <= 1'b0;
      do @(negedge clock); while (replies_due.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver stall pattern: phases of no, light, heavy and solid back-pressure
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_kind'($urandom_range(0, 3));
         stall_left = (stall_mode == STALL_BLOCK) ? $urandom_range(5, 40)
                                                  : $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      reply_t want;
      if (!reset && req_valid && !req_stall) begin
         want = apply_request(op_type'(req_op), req_value, req_priority_req);
         if (row_typed) want = row_want;
         replies_due.push_back(want);
      end
   end

   always @(posedge clock) begin
      reply_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $error("result transaction with no request outstanding");
            error_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_head_value !== want.value) begin
               $error("head_value: expected %0d, got %0d", want.value, rsp_head_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
